FILE: rtl/core/rwpb_pkg.sv
package rwpb_pkg;

   // Default upper bound on the number of points in one sequence.
   localparam int MaxPointsDefault = 1024;

   // Field widths.
   localparam int GqWidth  = 31;
   localparam int ValWidth = 32;
   localparam int ColWidth = 10;
   localparam int ProdWidth = 2 * GqWidth;

   // Stream payload widths, padded to whole bytes.
   localparam int ReqDataWidth = 128;
   localparam int RspDataWidth = 112;

   localparam logic signed [ValWidth-1:0] ValMax = 32'sh7FFF_FFFF;
   localparam logic signed [ValWidth-1:0] ValMin = 32'sh8000_0000;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PROD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_W_SET,
      OP_MUL,
      OP_RND,
      OP_ACC,
      OP_EMIT_MAIN,
      OP_EMIT_TAIL
   } dp_op_type;

   // Operand pairs of the shared multiplier.
   typedef enum logic [2:0] {
      SEL_T1,
      SEL_T2,
      SEL_D0,
      SEL_D1,
      SEL_S10
   } mul_sel_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type sel;
      logic        tail_final;
   } dp_cmd_type;

   typedef struct packed {
      logic order;
      logic last;
      logic out_free;
   } dp_status_type;

   // Saturating signed 32-bit add.
   function automatic logic signed [ValWidth-1:0] add_sat(
      input logic signed [ValWidth-1:0] a,
      input logic signed [ValWidth-1:0] b
   );
      logic signed [ValWidth:0] s;
      s = {a[ValWidth-1], a} + {b[ValWidth-1], b};
      if (s[ValWidth] != s[ValWidth-1]) begin
         return s[ValWidth] ? ValMin : ValMax;
      end
      return s[ValWidth-1:0];
   endfunction

   // Round a Q32.32 product to Q16.16, halves up, with saturation.
   function automatic logic signed [ValWidth-1:0] round_q(
      input logic signed [2*ValWidth-1:0] y
   );
      logic signed [2*ValWidth-1:0] t;
      logic [2*ValWidth-17:0] r;
      t = y + 64'sd32768;
      r = t[2*ValWidth-1:16];
      if (r[2*ValWidth-17:ValWidth-1] != {(ValWidth-15){1'b0}} &&
          r[2*ValWidth-17:ValWidth-1] != {(ValWidth-15){1'b1}}) begin
         return r[2*ValWidth-17] ? ValMin : ValMax;
      end
      return r[ValWidth-1:0];
   endfunction

endpackage

FILE: rtl/core/rwpb_ctrl.sv
module rwpb_ctrl
   import rwpb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_CHECK,
      ST_DIV,
      ST_WSET,
      ST_MUL,
      ST_RND,
      ST_ACC,
      ST_EMIT,
      ST_TAIL
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   mul_sel_type sel_ff, sel_in;
   logic        tail_ff, tail_in;
   logic        tail_final;

   assign req_tready = (state_ff == ST_IDLE);
   assign tail_final = !status.order || tail_ff;

   // Next state and operation for the datapath.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      tail_in  = tail_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = sel_ff;
      cmd.tail_final = tail_final;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.op   = OP_PROD;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = 5'd30;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_WSET;
            end
         end
         ST_WSET: begin
            cmd.op   = OP_W_SET;
            sel_in   = SEL_T1;
            state_in = status.order ? ST_MUL : ST_ACC;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.op   = OP_RND;
            state_in = ST_MUL;
            case (sel_ff)
               SEL_T1:  sel_in = SEL_T2;
               SEL_T2:  sel_in = SEL_D0;
               SEL_D0:  sel_in = SEL_D1;
               SEL_D1:  sel_in = SEL_S10;
               default: state_in = ST_ACC;
            endcase
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT_MAIN;
               tail_in  = 1'b0;
               state_in = status.last ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.op  = OP_EMIT_TAIL;
               tail_in = 1'b1;
               if (tail_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 5'd0;
         sel_ff   <= SEL_T1;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

FILE: rtl/core/rwpb_dpath.sv
module rwpb_dpath
   import rwpb_pkg::*;
#(
   parameter int MAX_POINTS = MaxPointsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_data,
   input  logic [ReqDataWidth-1:0]    req_tdata,
   input  logic                       req_tlast,
   output logic [RspDataWidth-1:0]    rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status
);

   localparam int CW = $clog2(MAX_POINTS);

   // Configuration and captured point.
   logic                        order_cfg_ff;
   logic                        order_ff, last_ff;
   logic [GqWidth-1:0]          g_ff, q_ff;
   logic signed [ValWidth-1:0]  f1_ff, f2_ff;

   // Reciprocal weight unit.
   logic [ProdWidth-1:0]        p_ff;
   logic [ProdWidth-1:0]        num_full;
   logic [GqWidth-1:0]          num_ff;
   logic [ProdWidth-1:0]        rem_ff;
   logic [ProdWidth:0]          trial;
   logic [GqWidth-1:0]          quo_ff;
   logic                        ovf_ff;
   logic signed [ValWidth-1:0]  w_ff;

   // Shared multiplier.
   logic signed [ValWidth-1:0]   mul_a, mul_b;
   logic signed [2*ValWidth-1:0] prod_ff;
   logic signed [ValWidth-1:0]   rnd;
   logic signed [ValWidth-1:0]   t1_ff, t2_ff, d0t_ff, d1t_ff, s10t_ff;

   // Column sums and position.
   logic signed [ValWidth-1:0]  pd0_ff, pd1_ff, pd2_ff, ps10_ff, ps11_ff, ps20_ff;
   logic [CW-1:0]               count_ff;
   logic [CW+ColWidth-1:0]      count_ext;

   // Output register.
   logic                        valid_ff;
   logic [ColWidth-1:0]         col_ff;
   logic signed [ValWidth-1:0]  od_ff, os1_ff, os2_ff;
   logic                        olast_ff;

   assign num_full  = (ProdWidth'(1) << 48) + (p_ff >> 1);
   assign trial     = {rem_ff, num_ff[GqWidth-1]};
   assign rnd       = round_q(prod_ff);
   assign count_ext = {{ColWidth{1'b0}}, count_ff};

   assign status.order    = order_ff;
   assign status.last     = last_ff;
   assign status.out_free = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {{(RspDataWidth - ColWidth - 3*ValWidth){1'b0}},
                        os2_ff, os1_ff, od_ff, col_ff};

   // Operand pairs of the multiplier.
   always_comb begin
      case (cmd.sel)
         SEL_T1:  begin mul_a = w_ff;  mul_b = f1_ff; end
         SEL_T2:  begin mul_a = w_ff;  mul_b = f2_ff; end
         SEL_D0:  begin mul_a = t2_ff; mul_b = f2_ff; end
         SEL_D1:  begin mul_a = t1_ff; mul_b = f1_ff; end
         default: begin mul_a = t1_ff; mul_b = f2_ff; end
      endcase
   end

   // Control registers: configuration, sequence position, column sums and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_cfg_ff <= 1'b0;
         count_ff     <= '0;
         valid_ff     <= 1'b0;
         pd0_ff  <= '0;
         pd1_ff  <= '0;
         pd2_ff  <= '0;
         ps10_ff <= '0;
         ps11_ff <= '0;
         ps20_ff <= '0;
      end else begin
         if (csr_valid) begin
            order_cfg_ff <= csr_data;
         end
         // A new column loads the output register; otherwise a transfer empties it.
         if (cmd.op == OP_EMIT_MAIN || cmd.op == OP_EMIT_TAIL) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_ACC: begin
               if (!order_ff) begin
                  pd0_ff  <= add_sat(pd0_ff, w_ff);
                  pd1_ff  <= add_sat(pd1_ff, w_ff);
                  ps10_ff <= add_sat(ps10_ff, 32'sd0 - w_ff);
               end else begin
                  pd0_ff  <= add_sat(pd0_ff, d0t_ff);
                  pd1_ff  <= add_sat(pd1_ff, d1t_ff);
                  pd2_ff  <= add_sat(pd2_ff, w_ff);
                  ps10_ff <= add_sat(ps10_ff, s10t_ff);
                  ps11_ff <= add_sat(ps11_ff, t1_ff);
                  ps20_ff <= add_sat(ps20_ff, t2_ff);
               end
            end
            OP_EMIT_MAIN: begin
               pd0_ff  <= pd1_ff;
               pd1_ff  <= pd2_ff;
               pd2_ff  <= '0;
               ps10_ff <= ps11_ff;
               ps11_ff <= '0;
               ps20_ff <= '0;
               if (!last_ff) begin
                  if (count_ff == CW'(MAX_POINTS - 1)) begin
                     count_ff <= '0;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            OP_EMIT_TAIL: begin
               pd2_ff  <= '0;
               ps11_ff <= '0;
               // The final flushed column returns the sums to their reset state.
               if (cmd.tail_final) begin
                  count_ff <= '0;
                  pd0_ff   <= '0;
                  pd1_ff   <= '0;
                  ps10_ff  <= '0;
               end else begin
                  pd0_ff  <= pd1_ff;
                  pd1_ff  <= pd2_ff;
                  ps10_ff <= ps11_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers of the captured point, weight unit, multiplier and output.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            g_ff     <= req_tdata[GqWidth-1:0];
            q_ff     <= req_tdata[2*GqWidth-1:GqWidth];
            f1_ff    <= req_tdata[2*GqWidth+ValWidth-1:2*GqWidth];
            f2_ff    <= req_tdata[2*GqWidth+2*ValWidth-1:2*GqWidth+ValWidth];
            last_ff  <= req_tlast;
            order_ff <= order_cfg_ff;
         end
         OP_PROD: begin
            p_ff <= g_ff * q_ff;
         end
         OP_DIV_INIT: begin
            // The quotient overflows 31 bits when the numerator reaches p * 2^31.
            ovf_ff <= (p_ff == '0) ||
                      ((p_ff[ProdWidth-1:GqWidth] == '0) &&
                       (num_full >= {p_ff[GqWidth-1:0], {GqWidth{1'b0}}}));
            rem_ff <= {{GqWidth{1'b0}}, num_full[ProdWidth-1:GqWidth]};
            num_ff <= num_full[GqWidth-1:0];
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            // One restoring division step per cycle.
            num_ff <= {num_ff[GqWidth-2:0], 1'b0};
            if (trial >= {1'b0, p_ff}) begin
               rem_ff <= ProdWidth'(trial - {1'b0, p_ff});
               quo_ff <= {quo_ff[GqWidth-2:0], 1'b1};
            end else begin
               rem_ff <= trial[ProdWidth-1:0];
               quo_ff <= {quo_ff[GqWidth-2:0], 1'b0};
            end
         end
         OP_W_SET: begin
            w_ff <= ovf_ff ? ValMax : {1'b0, quo_ff};
         end
         OP_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         OP_RND: begin
            case (cmd.sel)
               SEL_T1:  t1_ff   <= rnd;
               SEL_T2:  t2_ff   <= rnd;
               SEL_D0:  d0t_ff  <= rnd;
               SEL_D1:  d1t_ff  <= rnd;
               default: s10t_ff <= rnd;
            endcase
         end
         OP_EMIT_MAIN: begin
            col_ff   <= count_ext[ColWidth-1:0];
            od_ff    <= pd0_ff;
            os1_ff   <= ps10_ff;
            os2_ff   <= ps20_ff;
            olast_ff <= 1'b0;
         end
         OP_EMIT_TAIL: begin
            col_ff   <= col_ff + 1'b1;
            od_ff    <= pd0_ff;
            os1_ff   <= ps10_ff;
            os2_ff   <= '0;
            olast_ff <= cmd.tail_final;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/core/random_walk_penalty_band_assembly_core.sv
// Banded precision matrix assembly for a weighted random walk prior.
// Points arrive on the req_ stream: g and q (unsigned Q15.16), the two
// difference weights (signed Q16.16) and tlast on the final point.
// Completed columns leave on the rsp_ stream as column index, diagonal,
// first and second subdiagonal, with tlast on the final column.
// The csr_ channel writes the walk order (0 first order, 1 second order);
// it is always ready and should only be written while the block is idle.
// A point holds the block through its product, divide, weight, multiply
// (second order only), accumulate and emit steps. The reciprocal
// weight comes from a restoring divider that retires one quotient bit
// per cycle (31 steps), and the five second-order products share one
// multiplier, each as a multiply step and then a rounding step.
// The next point is accepted once this point's results are in the output
// register. A last point adds one or two flushed columns, each sent
// when the output register is free.
// Reset clears the order, column position and all partial sums.
// When the receiver stalls, the result holds in the output register and
// the block waits before loading the next column.
module random_walk_penalty_band_assembly_core
   import rwpb_pkg::*;
#(
   parameter int MAX_POINTS = MaxPointsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   // Configuration write.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_data,       // walk_order
   // Point stream.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,      // g_value, q_value, f1_value, f2_value
   input  logic                    req_tlast,      // last_point
   // Column stream.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,      // column_index, diag_value, sub1_value, sub2_value
   output logic                    rsp_tlast       // last_column
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // Sequencer.
   rwpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic, column sums and output register.
   rwpb_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
